FILE: rtl/core/rtsp_pkg.sv
// ----------------------------------------------------------------------------
// Resistive touch sample processor package
// Shared widths, reset values, rotation codes, calibration tables and types.
// ----------------------------------------------------------------------------
`default_nettype none

package rtsp_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int PRESSURE_W = 13;
    localparam int PIXEL_W    = 9;
    localparam int ROT_W      = 2;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;

    localparam logic [PRESSURE_W-1:0] THRESHOLD_RESET = 13'd400;

    localparam logic [0:0] REG_THRESHOLD = 1'b0;
    localparam logic [0:0] REG_ROTATION  = 1'b1;

    localparam logic [ROT_W-1:0] ROT_0   = 2'd0;
    localparam logic [ROT_W-1:0] ROT_90  = 2'd1;
    localparam logic [ROT_W-1:0] ROT_180 = 2'd2;
    localparam logic [ROT_W-1:0] ROT_270 = 2'd3;

    localparam logic [ROT_W-1:0] ROTATION_RESET = ROT_0;

    // Reciprocals for the two pixel divisors, exact for any 12-bit dividend.
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_W     = 13;
    localparam int DIV_A       = 3615 / 240;
    localparam int DIV_B       = 3585 / 320;
    localparam logic [RECIP_W-1:0] RECIP_A = RECIP_W'(((1 << RECIP_SHIFT) + DIV_A - 1) / DIV_A);
    localparam logic [RECIP_W-1:0] RECIP_B = RECIP_W'(((1 << RECIP_SHIFT) + DIV_B - 1) / DIV_B);

    typedef struct packed {
        logic [SAMPLE_W-1:0] z1;
        logic [SAMPLE_W-1:0] z2;
        logic [SAMPLE_W-1:0] xa;
        logic [SAMPLE_W-1:0] xb;
        logic [SAMPLE_W-1:0] xc;
        logic [SAMPLE_W-1:0] ya;
        logic [SAMPLE_W-1:0] yb;
        logic [SAMPLE_W-1:0] yc;
    } sample_t;

    typedef struct packed {
        logic                  touched;
        logic [PRESSURE_W-1:0] pressure;
        logic [SAMPLE_W-1:0]   pos_x;
        logic [SAMPLE_W-1:0]   pos_y;
        logic [ROT_W-1:0]      rotation;
    } held_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] offset;
        logic [RECIP_W-1:0]  recip;
    } cal_t;

    function automatic cal_t x_cal(input logic [ROT_W-1:0] rot);
        cal_t c;
        case (rot)
            ROT_0:   c = '{offset: 12'd95,  recip: RECIP_A};
            ROT_90:  c = '{offset: 12'd160, recip: RECIP_B};
            ROT_180: c = '{offset: 12'd385, recip: RECIP_A};
            ROT_270: c = '{offset: 12'd351, recip: RECIP_B};
            default: c = '{offset: 12'd95,  recip: RECIP_A};
        endcase
        return c;
    endfunction

    function automatic cal_t y_cal(input logic [ROT_W-1:0] rot);
        cal_t c;
        case (rot)
            ROT_0:   c = '{offset: 12'd190, recip: RECIP_B};
            ROT_90:  c = '{offset: 12'd385, recip: RECIP_A};
            ROT_180: c = '{offset: 12'd305, recip: RECIP_B};
            ROT_270: c = '{offset: 12'd191, recip: RECIP_A};
            default: c = '{offset: 12'd190, recip: RECIP_B};
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/rtsp_regs.sv
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style write and read of the touch threshold and screen rotation.
// ----------------------------------------------------------------------------
`default_nettype none

module rtsp_regs (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [rtsp_pkg::ADDR_W-1:0]        paddr,
    input  wire logic [rtsp_pkg::DATA_W-1:0]        pwdata,
    output logic      [rtsp_pkg::DATA_W-1:0]        prdata,
    output logic                                    pready,
    output logic      [rtsp_pkg::PRESSURE_W-1:0]    threshold,
    output logic      [rtsp_pkg::ROT_W-1:0]         rotation
);

    logic [rtsp_pkg::PRESSURE_W-1:0] threshold_reg;
    logic [rtsp_pkg::PRESSURE_W-1:0] threshold_next;
    logic [rtsp_pkg::ROT_W-1:0]      rotation_reg;
    logic [rtsp_pkg::ROT_W-1:0]      rotation_next;
    logic                            wr_en;
    logic [0:0]                      reg_index;

    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite;
    assign reg_index = paddr[2:2];

    always_comb
    begin
        threshold_next = threshold_reg;
        rotation_next  = rotation_reg;
        if (wr_en)
        begin
            case (reg_index)
                rtsp_pkg::REG_THRESHOLD: threshold_next = pwdata[rtsp_pkg::PRESSURE_W-1:0];
                rtsp_pkg::REG_ROTATION:  rotation_next  = pwdata[rtsp_pkg::ROT_W-1:0];
                default:                 threshold_next = threshold_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= rtsp_pkg::THRESHOLD_RESET;
            rotation_reg  <= rtsp_pkg::ROTATION_RESET;
        end
        else
        begin
            threshold_reg <= threshold_next;
            rotation_reg  <= rotation_next;
        end
    end

    always_comb
    begin
        case (reg_index)
            rtsp_pkg::REG_THRESHOLD:
                prdata = {{(rtsp_pkg::DATA_W-rtsp_pkg::PRESSURE_W){1'b0}}, threshold_reg};
            rtsp_pkg::REG_ROTATION:
                prdata = {{(rtsp_pkg::DATA_W-rtsp_pkg::ROT_W){1'b0}}, rotation_reg};
            default:
                prdata = '0;
        endcase
    end

    assign threshold = threshold_reg;
    assign rotation  = rotation_reg;

endmodule

`default_nettype wire

FILE: rtl/core/rtsp_sample_stage.sv
// ----------------------------------------------------------------------------
// Sample stage
// Pressure and touch decision, closest-pair averaging, rotation and hold.
// ----------------------------------------------------------------------------
`default_nettype none

module rtsp_sample_stage (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic [rtsp_pkg::PRESSURE_W-1:0] threshold,
    input  wire logic [rtsp_pkg::ROT_W-1:0]      rotation,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire rtsp_pkg::sample_t               in_item,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output rtsp_pkg::held_t                      out_item
);

    logic                             valid_reg;
    rtsp_pkg::held_t                  item_reg;
    rtsp_pkg::held_t                  item_next;
    logic [rtsp_pkg::SAMPLE_W-1:0]    held_x_reg;
    logic [rtsp_pkg::SAMPLE_W-1:0]    held_y_reg;
    logic [rtsp_pkg::SAMPLE_W-1:0]    held_x_next;
    logic [rtsp_pkg::SAMPLE_W-1:0]    held_y_next;
    logic [rtsp_pkg::PRESSURE_W-1:0]  z_sum;
    logic                             hit;
    logic [rtsp_pkg::SAMPLE_W-1:0]    avg_x;
    logic [rtsp_pkg::SAMPLE_W-1:0]    avg_y;
    logic                             load;

    function automatic logic [rtsp_pkg::SAMPLE_W-1:0] abs_diff(
        input logic [rtsp_pkg::SAMPLE_W-1:0] p,
        input logic [rtsp_pkg::SAMPLE_W-1:0] q
    );
        return (p > q) ? (p - q) : (q - p);
    endfunction

    function automatic logic [rtsp_pkg::SAMPLE_W-1:0] pair_avg(
        input logic [rtsp_pkg::SAMPLE_W-1:0] a,
        input logic [rtsp_pkg::SAMPLE_W-1:0] b,
        input logic [rtsp_pkg::SAMPLE_W-1:0] c
    );
        logic [rtsp_pkg::SAMPLE_W-1:0] dab;
        logic [rtsp_pkg::SAMPLE_W-1:0] dac;
        logic [rtsp_pkg::SAMPLE_W-1:0] dbc;
        logic [rtsp_pkg::SAMPLE_W:0]   sum;
        dab = abs_diff(a, b);
        dac = abs_diff(a, c);
        dbc = abs_diff(b, c);
        if (dab <= dac && dab <= dbc)
            sum = {1'b0, a} + {1'b0, b};
        else if (dac <= dbc)
            sum = {1'b0, a} + {1'b0, c};
        else
            sum = {1'b0, b} + {1'b0, c};
        return sum[rtsp_pkg::SAMPLE_W:1];
    endfunction

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    // 4095 - z2 is the bitwise inverse of a 12-bit value
    assign z_sum = {1'b0, in_item.z1} + {1'b0, ~in_item.z2};
    assign hit   = (z_sum >= threshold);
    assign avg_x = pair_avg(in_item.xa, in_item.xb, in_item.xc);
    assign avg_y = pair_avg(in_item.ya, in_item.yb, in_item.yc);

    always_comb
    begin
        held_x_next = held_x_reg;
        held_y_next = held_y_reg;
        if (hit)
        begin
            case (rotation)
                rtsp_pkg::ROT_0:
                begin
                    held_x_next = ~avg_y;
                    held_y_next = avg_x;
                end
                rtsp_pkg::ROT_90:
                begin
                    held_x_next = avg_x;
                    held_y_next = avg_y;
                end
                rtsp_pkg::ROT_180:
                begin
                    held_x_next = avg_y;
                    held_y_next = ~avg_x;
                end
                default:
                begin
                    held_x_next = ~avg_x;
                    held_y_next = ~avg_y;
                end
            endcase
        end
        item_next.touched  = hit;
        item_next.pressure = hit ? z_sum : '0;
        item_next.pos_x    = held_x_next;
        item_next.pos_y    = held_y_next;
        item_next.rotation = rotation;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            held_x_reg <= '0;
            held_y_reg <= '0;
        end
        else
        begin
            if (in_ready)
                valid_reg <= in_valid;
            if (load)
            begin
                held_x_reg <= held_x_next;
                held_y_reg <= held_y_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    property p_hold_without_touch;
        @(posedge clk) disable iff (!rst_n)
        (load && !hit) |=> ($stable(held_x_reg) && $stable(held_y_reg));
    endproperty
    a_hold_without_touch: assert property (p_hold_without_touch)
        else $error("held position changed on an item without touch");

    property p_item_matches_held;
        @(posedge clk) disable iff (!rst_n)
        load |=> (item_reg.pos_x == held_x_reg && item_reg.pos_y == held_y_reg);
    endproperty
    a_item_matches_held: assert property (p_item_matches_held)
        else $error("staged position differs from held position");

endmodule

`default_nettype wire

FILE: rtl/core/rtsp_pixel_stage.sv
// ----------------------------------------------------------------------------
// Pixel stage
// Offset and constant division of the held position into screen pixels.
// ----------------------------------------------------------------------------
`default_nettype none

module rtsp_pixel_stage (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire rtsp_pkg::held_t                  in_item,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic                                  touched,
    output logic      [rtsp_pkg::PRESSURE_W-1:0]  pressure,
    output logic      [rtsp_pkg::PIXEL_W-1:0]     screen_x,
    output logic      [rtsp_pkg::PIXEL_W-1:0]     screen_y
);

    localparam int PROD_W = rtsp_pkg::SAMPLE_W + rtsp_pkg::RECIP_W;

    logic                            valid_reg;
    logic                            touched_reg;
    logic [rtsp_pkg::PRESSURE_W-1:0] pressure_reg;
    logic [rtsp_pkg::PIXEL_W-1:0]    screen_x_reg;
    logic [rtsp_pkg::PIXEL_W-1:0]    screen_y_reg;
    logic [rtsp_pkg::PIXEL_W-1:0]    screen_x_next;
    logic [rtsp_pkg::PIXEL_W-1:0]    screen_y_next;
    logic                            load;

    function automatic logic [rtsp_pkg::PIXEL_W-1:0] to_pixel(
        input logic [rtsp_pkg::SAMPLE_W-1:0] raw,
        input rtsp_pkg::cal_t                cal
    );
        logic [rtsp_pkg::SAMPLE_W-1:0] diff;
        logic [PROD_W-1:0]             prod;
        diff = raw - cal.offset;
        prod = {{rtsp_pkg::RECIP_W{1'b0}}, diff} * {{rtsp_pkg::SAMPLE_W{1'b0}}, cal.recip};
        if (raw < cal.offset)
            return '0;
        return prod[rtsp_pkg::RECIP_SHIFT +: rtsp_pkg::PIXEL_W];
    endfunction

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    assign screen_x_next = to_pixel(in_item.pos_x, rtsp_pkg::x_cal(in_item.rotation));
    assign screen_y_next = to_pixel(in_item.pos_y, rtsp_pkg::y_cal(in_item.rotation));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            touched_reg  <= in_item.touched;
            pressure_reg <= in_item.pressure;
            screen_x_reg <= screen_x_next;
            screen_y_reg <= screen_y_next;
        end
    end

    assign out_valid = valid_reg;
    assign touched   = touched_reg;
    assign pressure  = pressure_reg;
    assign screen_x  = screen_x_reg;
    assign screen_y  = screen_y_reg;

    property p_idle_pressure_zero;
        @(posedge clk) disable iff (!rst_n)
        (valid_reg && !touched_reg) |-> (pressure_reg == '0);
    endproperty
    a_idle_pressure_zero: assert property (p_idle_pressure_zero)
        else $error("nonzero pressure on an item without touch");

    property p_pixel_range;
        @(posedge clk) disable iff (!rst_n)
        valid_reg |-> (screen_x_reg <= 9'd372 && screen_y_reg <= 9'd372);
    endproperty
    a_pixel_range: assert property (p_pixel_range)
        else $error("pixel coordinate beyond full-scale quotient");

endmodule

`default_nettype wire

FILE: rtl/core/resistive_touch_sample_processor.sv
// ----------------------------------------------------------------------------
// Resistive touch sample processor
// Pressure, closest-pair position, rotation and pixel calibration per item.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------
//  input    | in_valid / in_ready    | z1/z2 samples, three X, three Y samples
//  output   | out_valid / out_ready  | touched, pressure, screen_x, screen_y
//  config   | psel/penable/pwrite    | paddr, pwdata, prdata (pready high)
//
//  One item per cycle while out_ready is high; out_valid rises once the item
//  has passed the input register, sample stage with held position and pixel stage.
//  Reset loads threshold 400, rotation 0 and held position 0.
//  A stalled output holds each full stage; ready passes back through all
//  three stages in the same cycle, so an empty stage accepts at once.
// ----------------------------------------------------------------------------
`default_nettype none

module resistive_touch_sample_processor (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [rtsp_pkg::ADDR_W-1:0]         paddr,
    input  wire logic [rtsp_pkg::DATA_W-1:0]         pwdata,
    output logic      [rtsp_pkg::DATA_W-1:0]         prdata,
    output logic                                     pready,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [rtsp_pkg::SAMPLE_W-1:0]       z1_sample,
    input  wire logic [rtsp_pkg::SAMPLE_W-1:0]       z2_sample,
    input  wire logic [rtsp_pkg::SAMPLE_W-1:0]       x_sample_a,
    input  wire logic [rtsp_pkg::SAMPLE_W-1:0]       x_sample_b,
    input  wire logic [rtsp_pkg::SAMPLE_W-1:0]       x_sample_c,
    input  wire logic [rtsp_pkg::SAMPLE_W-1:0]       y_sample_a,
    input  wire logic [rtsp_pkg::SAMPLE_W-1:0]       y_sample_b,
    input  wire logic [rtsp_pkg::SAMPLE_W-1:0]       y_sample_c,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic                                     touched,
    output logic      [rtsp_pkg::PRESSURE_W-1:0]     pressure,
    output logic      [rtsp_pkg::PIXEL_W-1:0]        screen_x,
    output logic      [rtsp_pkg::PIXEL_W-1:0]        screen_y
);

    logic [rtsp_pkg::PRESSURE_W-1:0] threshold;
    logic [rtsp_pkg::ROT_W-1:0]      rotation;

    logic                            in_valid_reg;
    rtsp_pkg::sample_t               in_item_reg;
    rtsp_pkg::sample_t               in_item_next;
    logic                            smp_ready;
    logic                            smp_valid;
    rtsp_pkg::held_t                 smp_item;
    logic                            pix_ready;

    assign in_item_next = '{z1: z1_sample,  z2: z2_sample,
                            xa: x_sample_a, xb: x_sample_b, xc: x_sample_c,
                            ya: y_sample_a, yb: y_sample_b, yc: y_sample_c};

    assign in_ready = !in_valid_reg || smp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_item_reg <= in_item_next;
    end

    rtsp_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .threshold (threshold),
        .rotation  (rotation)
    );

    rtsp_sample_stage u_sample (
        .clk       (clk),
        .rst_n     (rst_n),
        .threshold (threshold),
        .rotation  (rotation),
        .in_valid  (in_valid_reg),
        .in_ready  (smp_ready),
        .in_item   (in_item_reg),
        .out_valid (smp_valid),
        .out_ready (pix_ready),
        .out_item  (smp_item)
    );

    rtsp_pixel_stage u_pixel (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (smp_valid),
        .in_ready  (pix_ready),
        .in_item   (smp_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .touched   (touched),
        .pressure  (pressure),
        .screen_x  (screen_x),
        .screen_y  (screen_y)
    );

endmodule

`default_nettype wire
